[src/fsot_pkg.sv]
// ----------------------------------------------------------------------------
// fsot_pkg: shared definitions for the first-free slot owner table
// Field widths, operation codes, sequencer states and the search result type.
// ----------------------------------------------------------------------------
package fsot_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SLOTS_DEF  = 256;
    localparam int OWNER_BITS_DEF = 16;

    // Fixed field widths of the ports
    localparam int ID_W   = 16;
    localparam int SLOT_W = 9;
    localparam int MODE_W = 2;

    // Occupancy bitmap is searched one word per cycle
    localparam int WORD_BITS = 32;
    localparam int POS_BITS  = 5;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

    // Result status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } state_t;

    // Result of a find-first-free search over one bitmap word
    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] pos;
    } find_t;

endpackage

[src/fsot_find_free.sv]
// ----------------------------------------------------------------------------
// fsot_find_free: find-first-zero encoder over one bitmap word
// Reports whether the word holds a free slot and the lowest free position.
// ----------------------------------------------------------------------------
module fsot_find_free (
    input  logic [fsot_pkg::WORD_BITS-1:0] occ_word,
    output fsot_pkg::find_t                result
);

    // Walk from the top so the lowest free bit wins
    always_comb begin
        result.found = ~&occ_word;
        result.pos   = '0;
        for (int i = fsot_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (!occ_word[i]) begin
                result.pos = fsot_pkg::POS_BITS'(i);
            end
        end
    end

endmodule

[src/fsot_table.sv]
// ----------------------------------------------------------------------------
// fsot_table: owner storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fsot_table #(
    parameter int DEPTH = fsot_pkg::MAX_SLOTS_DEF,
    parameter int WIDTH = fsot_pkg::OWNER_BITS_DEF,
    parameter int AW    = $clog2(fsot_pkg::MAX_SLOTS_DEF)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write owner, register read data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/first_free_slot_owner_table_top.sv]
// ----------------------------------------------------------------------------
// first_free_slot_owner_table_top: first-fit slot allocator
// Reserve, release and query slots of an owner table under a small sequencer.
// ----------------------------------------------------------------------------
// One beat in, one beat out. Reserve scans the 32-bit occupancy words in the
// scan state up to and including the one holding the lowest free slot (one
// word per cycle through the find-first-free encoder); release and query wait
// in the read state for the registered read of the owner memory. Rejected
// requests go straight to the done state. The input side is ready only in the
// idle state; a finished result waits in the output register while the next
// beat is taken. Writing cfg_wdata clears every slot at once through the
// occupancy bitmap, so there is no clearing pass; a slot whose bit is clear
// reads as free, owner zero.
module first_free_slot_owner_table_top #(
    parameter int MAX_SLOTS  = fsot_pkg::MAX_SLOTS_DEF,
    parameter int OWNER_BITS = fsot_pkg::OWNER_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration
    input  logic                        cfg_we,
    input  logic [fsot_pkg::SLOT_W-1:0] cfg_wdata,
    // Request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [fsot_pkg::MODE_W-1:0] s_mode,
    input  logic [fsot_pkg::ID_W-1:0]   s_owner_id,
    input  logic [fsot_pkg::SLOT_W-1:0] s_slot_number,
    // Result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status,
    output logic [fsot_pkg::SLOT_W-1:0] m_granted_slot,
    output logic [fsot_pkg::ID_W-1:0]   m_slot_owner,
    output logic [fsot_pkg::SLOT_W-1:0] m_free_count,
    output logic [fsot_pkg::SLOT_W-1:0] m_occupied_count
);

    localparam int WB      = fsot_pkg::WORD_BITS;
    localparam int PB      = fsot_pkg::POS_BITS;
    localparam int SW      = fsot_pkg::SLOT_W;
    localparam int NWORDS  = (MAX_SLOTS + WB - 1) / WB;
    localparam int WORD_AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int IDX_W   = WORD_AW + PB;
    localparam int MEM_AW  = $clog2(MAX_SLOTS);

    fsot_pkg::state_t state_reg, state_next;

    logic [fsot_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [OWNER_BITS-1:0]       owner_reg, owner_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [WORD_AW-1:0]          word_reg, word_next;
    logic [SW-1:0]               cap_reg, cap_next;
    logic [SW-1:0]               cnt_reg, cnt_next;
    logic [WB-1:0]               occ_reg  [NWORDS];
    logic [WB-1:0]               occ_next [NWORDS];

    logic                  res_status_reg, res_status_next;
    logic [SW-1:0]         res_granted_reg, res_granted_next;
    logic [OWNER_BITS-1:0] res_who_reg, res_who_next;

    logic                        m_valid_reg, m_valid_next;
    logic                        m_status_reg, m_status_next;
    logic [SW-1:0]               m_granted_reg, m_granted_next;
    logic [fsot_pkg::ID_W-1:0]   m_owner_reg, m_owner_next;
    logic [SW-1:0]               m_free_reg, m_free_next;
    logic [SW-1:0]               m_occ_cnt_reg, m_occ_cnt_next;

    logic                  mem_we;
    logic [MEM_AW-1:0]     mem_waddr;
    logic [MEM_AW-1:0]     mem_raddr;
    logic [OWNER_BITS-1:0] mem_rdata;

    logic [OWNER_BITS-1:0] owner_in;
    logic [IDX_W-1:0]      in_idx;
    logic                  in_slot_ok;
    logic [IDX_W-1:0]      found_idx;
    logic                  occ_bit;
    fsot_pkg::find_t       find;

    // Mask the owner id, turn the slot number into a zero-based index
    assign owner_in   = OWNER_BITS'(32'(s_owner_id));
    assign in_idx     = IDX_W'(s_slot_number - SW'(1));
    assign in_slot_ok = (cap_reg != '0) && (s_slot_number != '0) &&
                        (s_slot_number <= cap_reg);
    assign mem_raddr  = MEM_AW'(in_idx);

    // Shared search unit over the current bitmap word
    fsot_find_free u_find (
        .occ_word (occ_reg[word_reg]),
        .result   (find)
    );

    assign found_idx = {word_reg, find.pos};
    assign occ_bit   = occ_reg[idx_reg[IDX_W-1:PB]][idx_reg[PB-1:0]];

    fsot_table #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (OWNER_BITS),
        .AW    (MEM_AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (owner_reg),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Sequencer: next state, datapath and memory control
    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        owner_next       = owner_reg;
        idx_next         = idx_reg;
        word_next        = word_reg;
        cap_next         = cap_reg;
        cnt_next         = cnt_reg;
        occ_next         = occ_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        res_who_next     = res_who_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_granted_next   = m_granted_reg;
        m_owner_next     = m_owner_reg;
        m_free_next      = m_free_reg;
        m_occ_cnt_next   = m_occ_cnt_reg;
        mem_we           = 1'b0;
        mem_waddr        = MEM_AW'(found_idx);

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            fsot_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_next        = s_mode;
                    owner_next       = owner_in;
                    idx_next         = in_idx;
                    word_next        = '0;
                    res_status_next  = fsot_pkg::STATUS_REJECT;
                    res_granted_next = '0;
                    res_who_next     = '0;
                    state_next       = fsot_pkg::ST_DONE;
                    case (s_mode)
                        fsot_pkg::MODE_RESERVE: begin
                            if (cap_reg != '0 && owner_in != '0 && cnt_reg < cap_reg) begin
                                state_next = fsot_pkg::ST_SCAN;
                            end
                        end
                        fsot_pkg::MODE_RELEASE, fsot_pkg::MODE_QUERY: begin
                            if (in_slot_ok) begin
                                state_next = fsot_pkg::ST_READ;
                            end
                        end
                        default: begin
                            state_next = fsot_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // Scan one bitmap word per cycle; claim the lowest free slot
            fsot_pkg::ST_SCAN: begin
                if (find.found) begin
                    occ_next[word_reg][find.pos] = 1'b1;
                    mem_we           = 1'b1;
                    cnt_next         = cnt_reg + SW'(1);
                    res_status_next  = fsot_pkg::STATUS_OK;
                    res_granted_next = SW'(32'(found_idx) + 32'd1);
                    state_next       = fsot_pkg::ST_DONE;
                end else begin
                    word_next = word_reg + WORD_AW'(1);
                end
            end

            // Owner word is back from memory
            fsot_pkg::ST_READ: begin
                if (mode_reg == fsot_pkg::MODE_RELEASE) begin
                    if (occ_bit) begin
                        occ_next[idx_reg[IDX_W-1:PB]][idx_reg[PB-1:0]] = 1'b0;
                        cnt_next        = cnt_reg - SW'(1);
                        res_who_next    = mem_rdata;
                        res_status_next = fsot_pkg::STATUS_OK;
                    end
                end else begin
                    res_who_next    = occ_bit ? mem_rdata : '0;
                    res_status_next = fsot_pkg::STATUS_OK;
                end
                state_next = fsot_pkg::ST_DONE;
            end

            // Hand the result to the output register when it is free
            fsot_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_granted_next = res_granted_reg;
                    m_owner_next   = fsot_pkg::ID_W'(32'(res_who_reg));
                    m_free_next    = cap_reg - cnt_reg;
                    m_occ_cnt_next = cnt_reg;
                    state_next     = fsot_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = fsot_pkg::ST_IDLE;
            end
        endcase

        // Capacity write: saturate and free every slot
        if (cfg_we) begin
            cap_next = (32'(cfg_wdata) > MAX_SLOTS) ? SW'(MAX_SLOTS) : cfg_wdata;
            cnt_next = '0;
            for (int w = 0; w < NWORDS; w++) begin
                occ_next[w] = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fsot_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            cap_reg     <= '0;
            cnt_reg     <= '0;
            for (int w = 0; w < NWORDS; w++) begin
                occ_reg[w] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cap_reg     <= cap_next;
            cnt_reg     <= cnt_next;
            occ_reg     <= occ_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg        <= mode_next;
        owner_reg       <= owner_next;
        idx_reg         <= idx_next;
        word_reg        <= word_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        res_who_reg     <= res_who_next;
        m_status_reg    <= m_status_next;
        m_granted_reg   <= m_granted_next;
        m_owner_reg     <= m_owner_next;
        m_free_reg      <= m_free_next;
        m_occ_cnt_reg   <= m_occ_cnt_next;
    end

    assign s_ready          = (state_reg == fsot_pkg::ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_granted_slot   = m_granted_reg;
    assign m_slot_owner     = m_owner_reg;
    assign m_free_count     = m_free_reg;
    assign m_occupied_count = m_occ_cnt_reg;

endmodule
